/* rtl/core/modbus_fixed_frame_checker_defines.svh */
// Assertion macros shared by the frame checker RTL.
`ifndef MODBUS_FIXED_FRAME_CHECKER_DEFINES_SVH
`define MODBUS_FIXED_FRAME_CHECKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MFF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MFF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/mff_pkg.sv */
`default_nettype none
package mff_pkg;

	localparam int FRAME_BYTES = 8;
	localparam int POS_W = $clog2(FRAME_BYTES);
	localparam logic [POS_W-1:0] POS_FIRST = '0;
	localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(FRAME_BYTES - 2);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

	localparam logic [15:0] CRC_PRESET = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam int SLOT_COUNT = 3;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDR_0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDR_1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDR_2 = 2'd2;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_ADDR = 2'd1;
	localparam logic [1:0] STATUS_CRC = 2'd2;

	localparam logic [1:0] SLOT_0 = 2'd0;
	localparam logic [1:0] SLOT_1 = 2'd1;
	localparam logic [1:0] SLOT_2 = 2'd2;

	typedef struct packed {
		logic       hit;
		logic [1:0] slot;
	} match_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/modbus_fixed_frame_checker.sv */
// A frame result is registered after its last byte is accepted; the byte
// waits in the input register while the CRC compare and address match feed the result register.
// Throughput: one byte per cycle; only the last byte of a frame waits on a full
// result register. The CRC of a byte is one eight-step combinational update.
// Reset: arst_n clears the frame position, held address and CRC-low bytes and address registers, and presets the CRC.
`default_nettype none
`include "modbus_fixed_frame_checker_defines.svh"
module modbus_fixed_frame_checker
	import mff_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output      logic                 s_axis_tready,
	input  wire logic [7:0]           s_axis_tdata,  // [7:0] rx_byte
	output      logic                 m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// [1:0] frame_status, [9:2] slave_address, [11:10] matched_slot,
	// [12] led_on, [28:13] computed_crc, [31:29] zero
	output      logic [31:0]          m_axis_tdata,
	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data
);

	logic [7:0]       slave_addr_q [SLOT_COUNT];
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic [POS_W-1:0] pos_q;
	logic [15:0]      crc_q;
	logic [7:0]       addr_q;
	logic [7:0]       crc_lo_q;
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [7:0]       out_addr_q;
	logic [1:0]       slot_q;
	logic             led_q;
	logic [15:0]      out_crc_q;
	logic             is_last;
	logic             fire_s1;
	logic             crc_ok;
	match_t           match;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q[0] <= '0;
			slave_addr_q[1] <= '0;
			slave_addr_q[2] <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SLAVE_ADDR_0: slave_addr_q[0] <= cfg_data;
				REG_SLAVE_ADDR_1: slave_addr_q[1] <= cfg_data;
				REG_SLAVE_ADDR_2: slave_addr_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign is_last = (pos_q == POS_LAST);
	assign fire_s1 = valid_s1 && (!is_last || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	mff_addr_match u_addr_match (
		.addr       (addr_q),
		.slave_addr (slave_addr_q),
		.match      (match)
	);

	assign crc_ok = (crc_q[7:0] == crc_lo_q) && (crc_q[15:8] == byte_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_FIRST;
			crc_q <= CRC_PRESET;
			addr_q <= '0;
			crc_lo_q <= '0;
		end else if (fire_s1) begin
			if (pos_q == POS_FIRST) begin
				addr_q <= byte_s1;
			end
			if (is_last) begin
				pos_q <= POS_FIRST;
				crc_q <= CRC_PRESET;
			end else begin
				pos_q <= pos_q + 1'b1;
				if (pos_q == POS_CRC_LO) begin
					crc_lo_q <= byte_s1;
				end else begin
					crc_q <= crc16_byte(crc_q, byte_s1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && is_last) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && is_last) begin
			if (!match.hit) begin
				status_q <= STATUS_ADDR;
			end else if (crc_ok) begin
				status_q <= STATUS_OK;
			end else begin
				status_q <= STATUS_CRC;
			end
			out_addr_q <= addr_q;
			slot_q <= match.slot;
			led_q <= match.hit;
			out_crc_q <= crc_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {3'b000, out_crc_q, led_q, slot_q, out_addr_q, status_q};

	`MFF_ASSERT_SAME(a_led_status, clk, arst_n, out_valid_q, (led_q == (status_q != STATUS_ADDR)), "LED state disagrees with frame status")
	`MFF_ASSERT_SAME(a_slot_nohit, clk, arst_n, out_valid_q && !led_q, (slot_q == SLOT_0), "Unmatched frame reports a nonzero slot")
	`MFF_ASSERT_NEXT(a_result_out, clk, arst_n, fire_s1 && is_last, out_valid_q, "Last byte of a frame gave no result")
	`MFF_ASSERT_NEXT(a_frame_reset, clk, arst_n, fire_s1 && is_last, (pos_q == POS_FIRST) && (crc_q == CRC_PRESET), "Frame state not restarted after last byte")

endmodule
`default_nettype wire

/* rtl/core/mff_addr_match.sv */
`default_nettype none
module mff_addr_match
	import mff_pkg::*;
(
	input  wire logic [7:0] addr,
	input  wire logic [7:0] slave_addr [SLOT_COUNT],
	output match_t          match
);

	// The lowest register index wins when several hold the same address.
	always_comb begin
		match.hit = 1'b1;
		match.slot = SLOT_0;
		if (slave_addr[0] == addr) begin
			match.slot = SLOT_0;
		end else if (slave_addr[1] == addr) begin
			match.slot = SLOT_1;
		end else if (slave_addr[2] == addr) begin
			match.slot = SLOT_2;
		end else begin
			match.hit = 1'b0;
			match.slot = SLOT_0;
		end
	end

endmodule
`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import mff_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_BYTES = 240;
	localparam int PHASE_COUNT = 6;

	typedef enum {FR_GOOD, FR_BAD_CRC, FR_FOREIGN, FR_NOISE} frame_kind_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  address;
		logic [1:0]  slot;
		logic        led;
		logic [15:0] crc;
	} frame_result_t;

	class frame_scoreboard;
		logic [7:0]    slot_addr [SLOT_COUNT];
		int unsigned   position;
		logic [15:0]   crc;
		logic [7:0]    held_addr;
		logic [7:0]    held_crc_lo;
		frame_result_t result_q [$];
		int            errors;
		int            frames_checked;

		function new();
			foreach (slot_addr[i]) begin
				slot_addr[i] = 8'h00;
			end
			position = 0;
			crc = CRC_PRESET;
			held_addr = 8'h00;
			held_crc_lo = 8'h00;
			errors = 0;
			frames_checked = 0;
		endfunction

		// Bits of the data byte enter at the low end one at a time.
		static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
			logic mix;
			for (int i = 0; i < 8; i++) begin
				mix = c[0] ^ b[i];
				c = c >> 1;
				if (mix) begin
					c = c ^ CRC_POLY;
				end
			end
			return c;
		endfunction

		function void set_slot(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
			if (idx < SLOT_COUNT) begin
				slot_addr[idx] = value;
			end
		endfunction

		function void note_byte(logic [7:0] b);
			frame_result_t r;
			if (position == 0) begin
				held_addr = b;
			end
			if (position < FRAME_BYTES - 2) begin
				crc = crc_step(crc, b);
				position++;
			end else if (position == FRAME_BYTES - 2) begin
				held_crc_lo = b;
				position++;
			end else begin
				r.led = 1'b0;
				r.slot = SLOT_0;
				for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
					if (slot_addr[i] == held_addr) begin
						r.led = 1'b1;
						r.slot = 2'(i);
					end
				end
				if (!r.led) begin
					r.status = STATUS_ADDR;
				end else if (crc == {b, held_crc_lo}) begin
					r.status = STATUS_OK;
				end else begin
					r.status = STATUS_CRC;
				end
				r.address = held_addr;
				r.crc = crc;
				result_q.push_back(r);
				position = 0;
				crc = CRC_PRESET;
			end
		endfunction

		function int pending();
			return result_q.size();
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [31:0] word);
			frame_result_t want;
			if (result_q.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %h", $time, word);
				errors++;
				return;
			end
			want = result_q.pop_front();
			frames_checked++;
			compare_field("frame_status", 16'(want.status), 16'(word[1:0]));
			compare_field("slave_address", 16'(want.address), 16'(word[9:2]));
			compare_field("matched_slot", 16'(want.slot), 16'(word[11:10]));
			compare_field("led_on", 16'(want.led), 16'(word[12]));
			compare_field("computed_crc", want.crc, word[28:13]);
			compare_field("padding", 16'h0000, 16'(word[31:29]));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	wire                  s_axis_tready;
	logic [7:0]           s_axis_tdata = 8'h00;
	wire                  m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	wire  [31:0]          m_axis_tdata;
	logic                 cfg_valid = 1'b0;
	wire                  cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SLAVE_ADDR_0;
	logic [7:0]           cfg_data = 8'h00;

	frame_scoreboard sb;
	logic [7:0]      cur_slots [SLOT_COUNT];
	int              bytes_sent = 0;
	int              settings_used = 0;
	bit              src_idle = 1'b0;
	bit              sink_idle = 1'b0;
	int              stall_left = 0;
	int              idle_cycles = 0;

	modbus_fixed_frame_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return $urandom_range(1, 3);
		end else if (r < 95) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [7:0] rand_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return 8'h00;
		end else if (r == 1) begin
			return 8'hFF;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (sink_idle && $urandom_range(0, 3) == 0) begin
			stall_left <= pick_gap() - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_result(m_axis_tdata);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	task automatic program_slots(input logic [7:0] a0, input logic [7:0] a1,
	                             input logic [7:0] a2);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [7:0]           val [4];
		idx = '{REG_UNUSED, REG_SLAVE_ADDR_0, REG_SLAVE_ADDR_1, REG_SLAVE_ADDR_2};
		val = '{8'($urandom_range(0, 255)), a0, a1, a2};
		for (int k = 0; k < 4; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= val[k];
			do @(posedge clk); while (!cfg_ready);
			sb.set_slot(idx[k], val[k]);
		end
		cfg_valid <= 1'b0;
		cur_slots = '{a0, a1, a2};
		settings_used++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		if (src_idle && $urandom_range(0, 2) == 0) begin
			gap = pick_gap();
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	// Pads out any broken frame first so that this one starts on a frame boundary.
	task automatic emit_frame(input logic [7:0] addr, input logic [7:0] pattern,
	                          input bit scramble, input bit corrupt);
		logic [7:0]  body [FRAME_BYTES];
		logic [15:0] c;
		while (bytes_sent % FRAME_BYTES != 0) begin
			send_byte(rand_byte());
		end
		body[0] = addr;
		for (int i = 1; i < FRAME_BYTES - 2; i++) begin
			body[i] = scramble ? rand_byte() : ((i % 2) ? pattern : ~pattern);
		end
		c = CRC_PRESET;
		for (int i = 0; i < FRAME_BYTES - 2; i++) begin
			c = frame_scoreboard::crc_step(c, body[i]);
		end
		if (corrupt) begin
			c = c ^ 16'($urandom_range(1, 65535));
		end
		body[FRAME_BYTES - 2] = c[7:0];
		body[FRAME_BYTES - 1] = c[15:8];
		for (int i = 0; i < FRAME_BYTES; i++) begin
			send_byte(body[i]);
		end
	endtask

	task automatic random_frame();
		int          r;
		frame_kind_t kind;
		r = $urandom_range(0, 99);
		kind = (r < 65) ? FR_GOOD : (r < 80) ? FR_BAD_CRC : (r < 92) ? FR_FOREIGN : FR_NOISE;
		case (kind)
			FR_GOOD: begin
				emit_frame(cur_slots[$urandom_range(0, SLOT_COUNT - 1)], 8'h00, 1'b1, 1'b0);
			end
			FR_BAD_CRC: begin
				emit_frame(cur_slots[$urandom_range(0, SLOT_COUNT - 1)], 8'h00, 1'b1, 1'b1);
			end
			FR_FOREIGN: begin
				emit_frame(rand_byte(), 8'h00, 1'b1, 1'($urandom_range(0, 1)));
			end
			default: begin
				repeat ($urandom_range(1, FRAME_BYTES - 1)) send_byte(rand_byte());
			end
		endcase
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int         phase_start;
		logic [7:0] a;
		logic [7:0] b;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two registers share an address, so the lower slot must win.
		program_slots(8'h11, 8'h22, 8'h22);
		emit_frame(8'h22, 8'h00, 1'b0, 1'b0);
		emit_frame(8'h5A, 8'hFF, 1'b0, 1'b1);
		emit_frame(8'h11, 8'h80, 1'b0, 1'b1);
		wait_idle();

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			a = 8'($urandom_range(0, 255));
			b = 8'($urandom_range(0, 255));
			case (phase)
				0: program_slots(8'h00, 8'h00, 8'h00);
				1: program_slots(8'hFF, 8'hFF, 8'hFF);
				2: program_slots(8'h00, 8'h80, 8'hFF);
				3: program_slots(a, a, b);
				default: program_slots(a, b, 8'($urandom_range(0, 255)));
			endcase
			src_idle = (phase != 2);
			sink_idle = (phase != 4);
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				random_frame();
			end
			wait_idle();
		end

		$display("testbench: %0d bytes sent, %0d frames checked", bytes_sent, sb.frames_checked);
		$display("testbench: %0d address settings, stalls on both sides", settings_used);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end
endmodule

/* modbus_fixed_frame_checker.f */
+incdir+rtl/core
rtl/core/mff_pkg.sv
rtl/core/mff_addr_match.sv
rtl/core/modbus_fixed_frame_checker.sv
verif/testbench.sv
